### hw/rtl/pwfe_pkg.sv
// ----------------------------------------------------------------------------
// pwfe_pkg
// Types and constants for the pulse-width frame encoder: line phases,
// register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package pwfe_pkg;

   localparam int unsigned FRAME_BITS  = 24;
   localparam int unsigned CNT_W       = 10;
   localparam int unsigned BITS_W      = 5;
   localparam int unsigned REP_W       = 4;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_BIT_HIGH  = 3'd1,
      PH_BIT_LOW   = 3'd2,
      PH_SYNC_HIGH = 3'd3,
      PH_SYNC_LOW  = 3'd4
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TIME_HIGH     = 3'd0,
      REG_TIME_LOW      = 3'd1,
      REG_SYNC_TIME     = 3'd2,
      REG_SENDER_ADDR   = 3'd3,
      REG_RECEIVER_ADDR = 3'd4,
      REG_REPEAT_COUNT  = 3'd5
   } reg_index_type;

   localparam logic [7:0]       RST_TIME_HIGH     = 8'd60;
   localparam logic [7:0]       RST_TIME_LOW      = 8'd20;
   localparam logic [7:0]       RST_SYNC_TIME     = 8'd208;
   localparam logic [7:0]       RST_SENDER_ADDR   = 8'd251;
   localparam logic [7:0]       RST_RECEIVER_ADDR = 8'd37;
   localparam logic [REP_W-1:0] RST_REPEAT_COUNT  = 4'd4;

endpackage

### hw/rtl/pulse_width_frame_encoder.sv
// ----------------------------------------------------------------------------
// pulse_width_frame_encoder
// Pulse-width line coder for a 24-bit remote-control frame (sender address,
// receiver address, data byte, MSB first), repeated a configurable count.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  req     | in        | req_valid / req_ready  | req_func, req_data_byte
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_line_level, rsp_busy_res,
//          |           |                        | rsp_frame_done, rsp_rejected
//  csr     | in        | csr_wr_en (no wait)    | csr_index, csr_wdata
//
//  The coder state and response register both load at the edge that accepts a
//  request, so a request can follow every cycle unless rsp_ready stalls them.
//  The response register decouples the sides: req_ready is high whenever the
//  response register is empty or being drained in the same cycle.
//  A stalled rsp_ready holds exactly one response and then drops req_ready.
//  Synchronous active-high reset returns the line to idle low, no response
//  pending, and the coder and configuration registers to their defaults.
//
module pulse_width_frame_encoder (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_line_level,
   output logic       rsp_busy_res,
   output logic       rsp_frame_done,
   output logic       rsp_rejected,
   // configuration port
   input  logic                              csr_wr_en,
   input  logic [pwfe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pwfe_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned CNT_W  = pwfe_pkg::CNT_W;
   localparam int unsigned BITS_W = pwfe_pkg::BITS_W;
   localparam int unsigned REP_W  = pwfe_pkg::REP_W;
   localparam int unsigned FB     = pwfe_pkg::FRAME_BITS;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [7:0]       time_high_ff, time_low_ff, sync_time_ff;
   logic [7:0]       sender_addr_ff, receiver_addr_ff;
   logic [REP_W-1:0] repeat_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_high_ff     <= pwfe_pkg::RST_TIME_HIGH;
         time_low_ff      <= pwfe_pkg::RST_TIME_LOW;
         sync_time_ff     <= pwfe_pkg::RST_SYNC_TIME;
         sender_addr_ff   <= pwfe_pkg::RST_SENDER_ADDR;
         receiver_addr_ff <= pwfe_pkg::RST_RECEIVER_ADDR;
         repeat_count_ff  <= pwfe_pkg::RST_REPEAT_COUNT;
      end else if (csr_wr_en) begin
         case (csr_index)
            pwfe_pkg::REG_TIME_HIGH:     time_high_ff     <= csr_wdata;
            pwfe_pkg::REG_TIME_LOW:      time_low_ff      <= csr_wdata;
            pwfe_pkg::REG_SYNC_TIME:     sync_time_ff     <= csr_wdata;
            pwfe_pkg::REG_SENDER_ADDR:   sender_addr_ff   <= csr_wdata;
            pwfe_pkg::REG_RECEIVER_ADDR: receiver_addr_ff <= csr_wdata;
            pwfe_pkg::REG_REPEAT_COUNT:  repeat_count_ff  <= csr_wdata[REP_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Coder state
   // ------------------------------------------------------------------------
   pwfe_pkg::phase_type phase_ff, phase_in;
   logic [FB-1:0]     shift_word_ff, shift_word_in;
   logic [BITS_W-1:0] bits_left_ff, bits_left_in;
   logic [CNT_W-1:0]  phase_ticks_ff, phase_ticks_in;
   logic [REP_W-1:0]  repeats_left_ff, repeats_left_in;
   logic              line_out_ff, line_out_in;
   logic [7:0]        saved_data_ff, saved_data_in;
   logic              done_in, rej_in;

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_line_ff, rsp_busy_ff, rsp_done_ff, rsp_rej_ff;

   logic req_fire;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Current phase length, compared live against the registers. Every phase
   // lasts at least one tick, so a zero length counts as one.
   logic [7:0]       high_len8, low_len8;
   logic [CNT_W-1:0] sync_low_len, phase_len, ticks_inc;
   logic             msb_one, phase_end;
   logic [REP_W-1:0] repeat_start, repeats_dec;

   always_comb begin
      msb_one      = shift_word_ff[FB-1];
      high_len8    = msb_one ? time_high_ff : time_low_ff;
      low_len8     = msb_one ? time_low_ff  : time_high_ff;
      // 3 * sync_time + time_low, at most 1020
      sync_low_len = {1'b0, sync_time_ff, 1'b0} + {2'b00, sync_time_ff}
                   + {2'b00, time_low_ff};
      case (phase_ff)
         pwfe_pkg::PH_BIT_HIGH:  phase_len = {2'b00, high_len8};
         pwfe_pkg::PH_BIT_LOW:   phase_len = {2'b00, low_len8};
         pwfe_pkg::PH_SYNC_HIGH: phase_len = {2'b00, time_low_ff};
         default:                phase_len = sync_low_len;
      endcase
      if (phase_len == '0) begin
         phase_len = CNT_W'(1);
      end
      ticks_inc    = phase_ticks_ff + CNT_W'(1);
      phase_end    = ticks_inc >= phase_len;
      repeat_start = (repeat_count_ff == '0) ? REP_W'(1) : repeat_count_ff;
      repeats_dec  = repeats_left_ff - REP_W'(1);
   end

   // Next-state logic
   always_comb begin
      phase_in        = phase_ff;
      shift_word_in   = shift_word_ff;
      bits_left_in    = bits_left_ff;
      phase_ticks_in  = phase_ticks_ff;
      repeats_left_in = repeats_left_ff;
      line_out_in     = line_out_ff;
      saved_data_in   = saved_data_ff;
      if (req_func) begin
         // start request: taken only when idle, no tick counted
         if (phase_ff == pwfe_pkg::PH_IDLE) begin
            saved_data_in   = req_data_byte;
            repeats_left_in = repeat_start;
            shift_word_in   = {sender_addr_ff, receiver_addr_ff, req_data_byte};
            bits_left_in    = BITS_W'(FB);
            phase_in        = pwfe_pkg::PH_BIT_HIGH;
            phase_ticks_in  = '0;
            line_out_in     = 1'b1;
         end
      end else if (phase_ff != pwfe_pkg::PH_IDLE) begin
         phase_ticks_in = ticks_inc;
         if (phase_end) begin
            phase_ticks_in = '0;
            case (phase_ff)
               pwfe_pkg::PH_BIT_HIGH: begin
                  phase_in    = pwfe_pkg::PH_BIT_LOW;
                  line_out_in = 1'b0;
               end
               pwfe_pkg::PH_BIT_LOW: begin
                  shift_word_in = {shift_word_ff[FB-2:0], 1'b0};
                  bits_left_in  = bits_left_ff - BITS_W'(1);
                  phase_in      = (bits_left_in == '0) ? pwfe_pkg::PH_SYNC_HIGH
                                                       : pwfe_pkg::PH_BIT_HIGH;
                  line_out_in   = 1'b1;
               end
               pwfe_pkg::PH_SYNC_HIGH: begin
                  phase_in    = pwfe_pkg::PH_SYNC_LOW;
                  line_out_in = 1'b0;
               end
               default: begin
                  // end of sync low: reload the frame or go idle
                  repeats_left_in = repeats_dec;
                  if (repeats_dec != '0) begin
                     shift_word_in = {sender_addr_ff, receiver_addr_ff, saved_data_ff};
                     bits_left_in  = BITS_W'(FB);
                     phase_in      = pwfe_pkg::PH_BIT_HIGH;
                     line_out_in   = 1'b1;
                  end else begin
                     phase_in    = pwfe_pkg::PH_IDLE;
                     line_out_in = 1'b0;
                  end
               end
            endcase
         end
      end
   end

   // Output logic: response flags and response valid
   always_comb begin
      rej_in  = req_func && (phase_ff != pwfe_pkg::PH_IDLE);
      done_in = !req_func && (phase_ff == pwfe_pkg::PH_SYNC_LOW) && phase_end
                && (repeats_dec == '0);
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= pwfe_pkg::PH_IDLE;
         shift_word_ff   <= '0;
         bits_left_ff    <= '0;
         phase_ticks_ff  <= '0;
         repeats_left_ff <= '0;
         line_out_ff     <= 1'b0;
         saved_data_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff        <= phase_in;
            shift_word_ff   <= shift_word_in;
            bits_left_ff    <= bits_left_in;
            phase_ticks_ff  <= phase_ticks_in;
            repeats_left_ff <= repeats_left_in;
            line_out_ff     <= line_out_in;
            saved_data_ff   <= saved_data_in;
         end
      end
   end

   // Response payload: load with each accepted request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_line_ff <= line_out_in;
         rsp_busy_ff <= (phase_in != pwfe_pkg::PH_IDLE);
         rsp_done_ff <= done_in;
         rsp_rej_ff  <= rej_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = rsp_line_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_frame_done = rsp_done_ff;
   assign rsp_rejected   = rsp_rej_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_idle_line_low: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pwfe_pkg::PH_IDLE |-> !line_out_ff)
      else $error("line high while idle");

   a_bits_in_frame: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pwfe_pkg::PH_BIT_HIGH || phase_ff == pwfe_pkg::PH_BIT_LOW)
      |-> bits_left_ff != '0)
      else $error("bit phase with no bits left");

   a_start_begins: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func && phase_ff == pwfe_pkg::PH_IDLE
      |=> phase_ff == pwfe_pkg::PH_BIT_HIGH && line_out_ff && bits_left_ff == BITS_W'(FB))
      else $error("start did not open a frame");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_busy_res && !rsp_rejected)
      else $error("frame done while still busy or rejected");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

endmodule
